// ----- hdl/month_calendar_layout_assert.svh -----
// Assertion macros for the month calendar layout block.
// Used by the top level; each macro expects signals named clk and rst_n in scope.
`ifndef MONTH_CALENDAR_LAYOUT_ASSERT_SVH
`define MONTH_CALENDAR_LAYOUT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MCL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("month_calendar_layout: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MCL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("month_calendar_layout: next-cycle check failed");

`endif

// ----- hdl/mcl_pkg.sv -----
// Shared types, constants and helper functions for the month calendar layout.
// Used by mcl_ctrl, mcl_dp and month_calendar_layout; depends on nothing.
package mcl_pkg;

    localparam int unsigned MAX_YEAR_DEFAULT = 9999;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int WD_W    = 3;
    localparam int ROW_W   = 3;

    // Reference point: 1 January 1990 was a Monday.
    localparam logic [YEAR_W-1:0] EPOCH_YEAR    = 14'd1990;
    localparam logic [WD_W-1:0]   EPOCH_WEEKDAY = 3'd1;
    localparam logic [8:0]        EPOCH_R400    = 9'd390;
    localparam logic [6:0]        EPOCH_R100    = 7'd90;
    localparam logic [8:0]        R400_LAST     = 9'd399;
    localparam logic [6:0]        R100_LAST     = 7'd99;

    localparam logic [MONTH_W-1:0] FIRST_MONTH = 4'd1;
    localparam logic [MONTH_W-1:0] FEBRUARY    = 4'd2;
    localparam logic [MONTH_W-1:0] LAST_MONTH  = 4'd12;
    localparam logic [WD_W-1:0]    SATURDAY    = 3'd6;
    localparam logic [WD_W-1:0]    SUNDAY      = 3'd0;
    localparam logic [DAY_W-1:0]   SHORT_MONTH = 5'd28;

    localparam logic [DAY_W-1:0] BASE_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic year_step;
        logic month_step;
        logic day_setup;
        logic emit;
    } mcl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_ok;
        logic year_done;
        logic month_done;
        logic day_last;
        logic out_free;
    } mcl_status_t;

    // Leap year from the year's residues modulo 400 and modulo 100.
    function automatic logic leap_of(input logic [8:0] r400, input logic [6:0] r100);
        return ((r400[1:0] == 2'd0) && (r100 != 7'd0)) || (r400 == 9'd0);
    endfunction

    // Length of month m (1..12) for a leap or common year.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [MONTH_W-1:0] idx;
        idx = m - FIRST_MONTH;
        if ((m == FEBRUARY) && leap)
            return BASE_LEN[idx] + 5'd1;
        return BASE_LEN[idx];
    endfunction

    // Sum of two values below 7, reduced modulo 7.
    function automatic logic [WD_W-1:0] add_mod7(input logic [WD_W-1:0] a,
                                                 input logic [WD_W-1:0] b);
        logic [WD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 4'd7)
            return WD_W'(s - 4'd7);
        return s[WD_W-1:0];
    endfunction

endpackage

// ----- hdl/month_calendar_layout.sv -----
// Usage: lays out one Gregorian month as a stream of day items.
// Input channel (in_valid/in_stall) takes a year and a month. Output channel
// (out_valid/out_stall) returns one item per day: day_number, weekday
// (0 = Sunday), grid_row, month_length and last_day on the final day.
// An item with a month outside 1..12 or a year above MAX_YEAR is taken and
// dropped without any output.
// Sequence: after acceptance the block walks one year per cycle from 1990 to the
// requested year, then through the months before the requested one (up to 11),
// then a setup step, then one day item per cycle while the receiver is free.
// The year walk is done in the datapath; one item is in work at a time.
// The next item is taken as soon as the last day item is loaded into the
// output register, while it may still wait for the receiver.
// When out_stall is high a valid output item holds and day emission pauses.
// Reset empties the output register and returns the sequencer to idle.
// Files: depends on mcl_pkg, mcl_ctrl, mcl_dp and the assertion header.
module month_calendar_layout
    import mcl_pkg::*;
#(
    parameter int unsigned MAX_YEAR = MAX_YEAR_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [YEAR_W-1:0]   year,
    input  logic [MONTH_W-1:0]  month,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [DAY_W-1:0]    day_number,
    output logic [WD_W-1:0]     weekday,
    output logic [ROW_W-1:0]    grid_row,
    output logic [DAY_W-1:0]    month_length,
    output logic                last_day
);

`include "month_calendar_layout_assert.svh"

    mcl_cmd_t    cmd;
    mcl_status_t status;

    // Sequencer.
    mcl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Counters and output register.
    mcl_dp #(
        .MAX_YEAR (MAX_YEAR)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .year         (year),
        .month        (month),
        .cmd          (cmd),
        .status       (status),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .day_number   (day_number),
        .weekday      (weekday),
        .grid_row     (grid_row),
        .month_length (month_length),
        .last_day     (last_day)
    );

    // A day item taken that is not the last one is followed at once by the next.
    `MCL_ASSERT_NEXT(a_days_continue, out_valid && !out_stall && !last_day, out_valid)
    // The final day item carries the month's length as its day number.
    `MCL_ASSERT_NOW(a_last_matches_len, out_valid && last_day, day_number == month_length)
    // Grid coordinates stay on the seven-by-six grid.
    `MCL_ASSERT_NOW(a_grid_bounds, out_valid, (weekday <= 3'd6) && (grid_row <= 3'd5))
    // No new item is taken during the year walk, the month walk or day emission.
    `MCL_ASSERT_NOW(a_no_load_busy, cmd.emit || cmd.year_step || cmd.month_step, in_stall)

endmodule

// ----- hdl/mcl_ctrl.sv -----
// Sequencer for the month calendar layout: year walk, month walk, day emission.
// Depends on mcl_pkg for the command and status structs.
module mcl_ctrl
    import mcl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  mcl_status_t status,
    output mcl_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_YEARS,
        S_MONTHS,
        S_DAYS
    } state_t;

    state_t state_reg, state_next;
    logic   stall_reg;

    // Next state and commands for the datapath.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.in_ok)
                        state_next = S_YEARS;
                end
            end
            S_YEARS:
            begin
                if (status.year_done)
                    state_next = S_MONTHS;
                else
                    cmd.year_step = 1'b1;
            end
            S_MONTHS:
            begin
                if (status.month_done)
                begin
                    cmd.day_setup = 1'b1;
                    state_next    = S_DAYS;
                end
                else
                    cmd.month_step = 1'b1;
            end
            S_DAYS:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.day_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and the registered input stall.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= (state_next != S_IDLE);
        end
    end

    assign in_stall = stall_reg;

endmodule

// ----- hdl/mcl_dp.sv -----
// Datapath for the month calendar layout: year and month walks, day counters
// and the output register. Depends on mcl_pkg; driven by mcl_ctrl commands.
module mcl_dp
    import mcl_pkg::*;
#(
    parameter int unsigned MAX_YEAR = MAX_YEAR_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [YEAR_W-1:0]   year,
    input  logic [MONTH_W-1:0]  month,
    input  mcl_cmd_t            cmd,
    output mcl_status_t         status,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [DAY_W-1:0]    day_number,
    output logic [WD_W-1:0]     weekday,
    output logic [ROW_W-1:0]    grid_row,
    output logic [DAY_W-1:0]    month_length,
    output logic                last_day
);

    logic [YEAR_W-1:0]  year_tgt_reg, cur_year_reg;
    logic [MONTH_W-1:0] month_tgt_reg, mcnt_reg;
    logic               fwd_reg;
    logic [8:0]         r400_reg, r400_next, r400_prev;
    logic [6:0]         r100_reg, r100_next, r100_prev;
    logic [WD_W-1:0]    wd_reg;
    logic [DAY_W-1:0]   day_reg, len_reg;
    logic [WD_W-1:0]    col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic               leap_cur, leap_prev;

    logic               out_valid_reg;
    logic [DAY_W-1:0]   out_day_reg, out_len_reg;
    logic [WD_W-1:0]    out_wd_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic               out_last_reg;

    // Residues of the neighboring years, used by the forward and backward walks.
    always_comb
    begin
        r400_next = (r400_reg == R400_LAST) ? 9'd0 : r400_reg + 9'd1;
        r100_next = (r100_reg == R100_LAST) ? 7'd0 : r100_reg + 7'd1;
        r400_prev = (r400_reg == 9'd0) ? R400_LAST : r400_reg - 9'd1;
        r100_prev = (r100_reg == 7'd0) ? R100_LAST : r100_reg - 7'd1;
        leap_cur  = leap_of(r400_reg, r100_reg);
        leap_prev = leap_of(r400_prev, r100_prev);
    end

    // Status toward the controller.
    always_comb
    begin
        status.in_ok      = (month >= FIRST_MONTH) && (month <= LAST_MONTH) &&
                            (32'(year) <= MAX_YEAR);
        status.year_done  = (cur_year_reg == year_tgt_reg);
        status.month_done = (mcnt_reg == month_tgt_reg);
        status.day_last   = (day_reg == len_reg);
        status.out_free   = !out_valid_reg || !out_stall;
    end

    // Walk registers: one year or one month per cycle, weekday kept modulo 7.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            year_tgt_reg  <= year;
            month_tgt_reg <= month;
            fwd_reg       <= (year >= EPOCH_YEAR);
            cur_year_reg  <= EPOCH_YEAR;
            r400_reg      <= EPOCH_R400;
            r100_reg      <= EPOCH_R100;
            wd_reg        <= EPOCH_WEEKDAY;
            mcnt_reg      <= FIRST_MONTH;
        end
        else if (cmd.year_step)
        begin
            if (fwd_reg)
            begin
                // Step over the current year, then move to the next one.
                wd_reg       <= add_mod7(wd_reg, leap_cur ? 3'd2 : 3'd1);
                cur_year_reg <= cur_year_reg + 14'd1;
                r400_reg     <= r400_next;
                r100_reg     <= r100_next;
            end
            else
            begin
                // Move to the previous year and take its length back off.
                wd_reg       <= add_mod7(wd_reg, leap_prev ? 3'd5 : 3'd6);
                cur_year_reg <= cur_year_reg - 14'd1;
                r400_reg     <= r400_prev;
                r100_reg     <= r100_prev;
            end
        end
        else if (cmd.month_step)
        begin
            wd_reg   <= add_mod7(wd_reg,
                                 WD_W'(month_len(mcnt_reg, leap_cur) - SHORT_MONTH));
            mcnt_reg <= mcnt_reg + 4'd1;
        end
    end

    // Day counters for the emission phase.
    always_ff @(posedge clk)
    begin
        if (cmd.day_setup)
        begin
            day_reg <= 5'd1;
            col_reg <= wd_reg;
            row_reg <= '0;
            len_reg <= month_len(month_tgt_reg, leap_cur);
        end
        else if (cmd.emit)
        begin
            day_reg <= day_reg + 5'd1;
            if (col_reg == SATURDAY)
            begin
                col_reg <= SUNDAY;
                row_reg <= row_reg + 3'd1;
            end
            else
                col_reg <= col_reg + 3'd1;
        end
    end

    // Output register: valid flag under reset, payload loaded on emit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_day_reg  <= day_reg;
            out_wd_reg   <= col_reg;
            out_row_reg  <= row_reg;
            out_len_reg  <= len_reg;
            out_last_reg <= (day_reg == len_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign day_number   = out_day_reg;
    assign weekday      = out_wd_reg;
    assign grid_row     = out_row_reg;
    assign month_length = out_len_reg;
    assign last_day     = out_last_reg;

endmodule

// ----- sim/month_calendar_layout_test.sv -----
// Self-checking testbench for month_calendar_layout: directed and random months go in,
// and each day item is checked against a day-count prediction of the month grid.
// Depends on mcl_pkg and the month_calendar_layout RTL only.
module month_calendar_layout_test;
    import mcl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_MONTHS = 66;
    localparam int TAIL_ITEMS    = 12;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 5000000;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
    } month_req_t;

    typedef struct packed {
        logic [DAY_W-1:0] day;
        logic [WD_W-1:0]  wd;
        logic [ROW_W-1:0] row;
        logic [DAY_W-1:0] len;
        logic             last;
    } cal_day_t;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [YEAR_W-1:0]  year      = '0;
    logic [MONTH_W-1:0] month     = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [DAY_W-1:0]   day_number;
    logic [WD_W-1:0]    weekday;
    logic [ROW_W-1:0]   grid_row;
    logic [DAY_W-1:0]   month_length;
    logic               last_day;

    month_req_t month_reqs[$];
    cal_day_t   days_due[$];
    logic       in_taken    = 1'b0;
    int         send_gap    = 0;
    int         stall_left  = 0;
    int         fail_count  = 0;
    int         cycle_count = 0;

    month_calendar_layout u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .year         (year),
        .month        (month),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .day_number   (day_number),
        .weekday      (weekday),
        .grid_row     (grid_row),
        .month_length (month_length),
        .last_day     (last_day)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Gregorian leap rule.
    function automatic bit leap_year(input longint y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int days_in_month(input longint y, input int m);
        case (m)
            4, 6, 9, 11: return 30;
            int'(FEBRUARY): return leap_year(y) ? 29 : 28;
            default: return 31;
        endcase
    endfunction

    // Whole days from 1 January of year 0 to the first of month m of year y.
    function automatic longint days_from_zero(input longint y, input int m);
        longint d;
        d = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        for (int k = 1; k < m; k++)
            d += days_in_month(y, k);
        return d;
    endfunction

    // Queue the day items that one accepted month should produce.
    task automatic predict_month(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m);
        longint   offset;
        int       first_wd;
        int       len;
        int       slot;
        cal_day_t entry;
        if (m < FIRST_MONTH || m > LAST_MONTH || y > MAX_YEAR_DEFAULT)
            return;
        offset = days_from_zero(y, m) - days_from_zero(EPOCH_YEAR, 1)
                 + 7 * 1000000 + EPOCH_WEEKDAY;
        first_wd = int'(offset % 7);
        len = days_in_month(y, m);
        for (int d = 1; d <= len; d++)
        begin
            slot = first_wd + d - 1;
            entry.day  = DAY_W'(d);
            entry.wd   = WD_W'(slot % 7);
            entry.row  = ROW_W'(slot / 7);
            entry.len  = DAY_W'(len);
            entry.last = (d == len);
            days_due.push_back(entry);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR at %0t ns: %s got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    // Input driver: holds a stalled item, then inserts random gaps between items.
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (in_valid && month_reqs.size() >= TAIL_ITEMS && $urandom_range(0, 3) == 0)
                send_gap = $urandom_range(1, 17);
            if (send_gap != 0)
            begin
                send_gap = send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (month_reqs.size() != 0)
            begin
                in_valid <= 1'b1;
                year     <= month_reqs[0].year;
                month    <= month_reqs[0].month;
                void'(month_reqs.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Output stall in random bursts, none near the end of the run.
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (rst_n && month_reqs.size() >= TAIL_ITEMS && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 16);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Monitor: predict on each accepted month, compare each accepted day item.
    always @(posedge clk)
    begin
        cal_day_t want;
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                predict_month(year, month);
            if (out_valid && !out_stall)
            begin
                if (days_due.size() == 0)
                    report_mismatch("unexpected day item, day_number", day_number, 0);
                else
                begin
                    want = days_due.pop_front();
                    check_field("day_number", day_number, want.day);
                    check_field("weekday", weekday, want.wd);
                    check_field("grid_row", grid_row, want.row);
                    check_field("month_length", month_length, want.len);
                    check_field("last_day", last_day, want.last);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        month_req_t req;
        int         taken;
        int         pick;

        // Directed: epoch edges, year extremes, leap rules, every month, ignored items.
        month_reqs.push_back('{14'd1990, 4'd1});
        month_reqs.push_back('{14'd1989, 4'd12});
        month_reqs.push_back('{14'd0, 4'd1});
        month_reqs.push_back('{14'd0, FEBRUARY});
        month_reqs.push_back('{14'd1, 4'd1});
        month_reqs.push_back('{14'd9999, 4'd12});
        month_reqs.push_back('{14'd2000, FEBRUARY});
        month_reqs.push_back('{14'd1900, FEBRUARY});
        month_reqs.push_back('{14'd2024, FEBRUARY});
        month_reqs.push_back('{14'd2023, FEBRUARY});
        month_reqs.push_back('{14'd2400, FEBRUARY});
        for (int m = 3; m <= 11; m++)
            month_reqs.push_back('{14'd2025, MONTH_W'(m)});
        month_reqs.push_back('{14'd2025, 4'd0});
        month_reqs.push_back('{14'd2025, 4'd13});
        month_reqs.push_back('{14'd16383, 4'd15});
        month_reqs.push_back('{14'd10000, 4'd6});
        month_reqs.push_back('{14'd16383, 4'd7});

        // Random: mostly years near the epoch, a few far ones, some ignored items.
        taken = 0;
        while (taken < RANDOM_MONTHS)
        begin
            pick = $urandom_range(0, 99);
            req.month = MONTH_W'($urandom_range(1, 12));
            if (pick < 80)
            begin
                req.year = YEAR_W'($urandom_range(1900, 2100));
                taken++;
            end
            else if (pick < 88)
            begin
                req.year = YEAR_W'($urandom_range(0, MAX_YEAR_DEFAULT));
                taken++;
            end
            else if (pick < 94)
                req.year = YEAR_W'($urandom_range(MAX_YEAR_DEFAULT + 1, 16383));
            else
            begin
                req.year  = YEAR_W'($urandom_range(0, 16383));
                req.month = (pick < 97) ? MONTH_W'(0) : MONTH_W'($urandom_range(13, 15));
            end
            month_reqs.push_back(req);
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (month_reqs.size() != 0 || in_valid)
            @(posedge clk);
        while (days_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- month_calendar_layout.f -----
+incdir+hdl
hdl/mcl_pkg.sv
hdl/mcl_ctrl.sv
hdl/mcl_dp.sv
hdl/month_calendar_layout.sv
sim/month_calendar_layout_test.sv
